// ===== rtl/tasi_pkg.sv =====
// Package: shared constants, command/status types for the tour swap improver.
`default_nettype none
package tasi_pkg;
	localparam int MAX_CITIES = 256;
	localparam int CITY_W     = 8;
	localparam int POS_W      = 9;
	localparam int CFG_W      = 9;
	localparam int COORD_W    = 16;
	localparam int FRAC_BITS  = 8;
	localparam int D2_W       = 2 * COORD_W + 1;
	localparam int RAD_W      = ((D2_W + 2 * FRAC_BITS + 1) / 2) * 2;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int CNT_W      = $clog2(ROOT_W + 1);
	localparam int COST_W     = 40;
	localparam int RUN_W      = COST_W + 1;
	localparam logic [COST_W-1:0] COST_MAX = '1;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_INIT = 2'd1;
	localparam logic [1:0] MODE_PASS = 2'd2;
	localparam logic [1:0] MODE_READ = 2'd3;

	typedef enum logic [2:0] {T_NONE, T_RD, T_RD_IDX, T_FILL, T_WR_C, T_WR_B} tour_op_t;
	typedef enum logic [1:0] {P_CD, P_AB, P_AC, P_BD} pair_t;
	typedef enum logic [1:0] {R_HOLD, R_CLR, R_ADD, R_SWAP} run_op_t;
	typedef enum logic [1:0] {RES_NONE, RES_ZERO, RES_PASS, RES_READ} res_op_t;

	typedef struct packed {
		logic     capture;
		logic     load;
		logic     best_rst;
		logic     bp_clr;
		logic     bp_inc;
		tour_op_t tour_op;
		logic [1:0] off;
		logic     shift;
		logic     crd;
		pair_t    pair;
		logic     dstart;
		logic     dsave;
		run_op_t  run_op;
		res_op_t  res_op;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic bp_eq_n;
		logic bp_eq_nm3;
		logic few;
		logic dist_done;
		logic better;
		logic out_busy;
	} sts_t;
endpackage
`default_nettype wire

// ===== rtl/tasi_dist.sv =====
// Distance unit: squares, sum and bit-pair square root, one root bit per cycle.
`default_nettype none
module tasi_dist (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [tasi_pkg::COORD_W-1:0] xa,
	input  wire logic [tasi_pkg::COORD_W-1:0] ya,
	input  wire logic [tasi_pkg::COORD_W-1:0] xb,
	input  wire logic [tasi_pkg::COORD_W-1:0] yb,
	output logic done,
	output logic [tasi_pkg::ROOT_W-1:0] root
);
	import tasi_pkg::*;

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001, D_SQ = 4'b0010, D_SUM = 4'b0100, D_ROOT = 4'b1000
	} dph_t;

	dph_t ph_q;
	logic [COORD_W-1:0] dx_q, dy_q;
	logic [2*COORD_W-1:0] sqx_q, sqy_q;
	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q, rem_sh, trial;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic done_q, ge;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= D_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				D_IDLE: if (start) ph_q <= D_SQ;
				D_SQ:   ph_q <= D_SUM;
				D_SUM: begin
					cnt_q <= CNT_W'(ROOT_W);
					ph_q  <= D_ROOT;
				end
				D_ROOT: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						done_q <= 1'b1;
						ph_q   <= D_IDLE;
					end
				end
				default: ph_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			D_IDLE: begin
				dx_q <= (xa > xb) ? xa - xb : xb - xa;
				dy_q <= (ya > yb) ? ya - yb : yb - ya;
			end
			D_SQ: begin
				sqx_q <= dx_q * dx_q;
				sqy_q <= dy_q * dy_q;
			end
			D_SUM: begin
				rad_q  <= RAD_W'(D2_W'(sqx_q) + D2_W'(sqy_q)) << (2 * FRAC_BITS);
				rem_q  <= '0;
				root_q <= '0;
			end
			D_ROOT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= ge ? rem_sh - trial : rem_sh;
				root_q <= {root_q[ROOT_W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ===== rtl/tasi_dpath.sv =====
// Datapath: city and tour memories, tour window, cost accumulator, result registers.
`default_nettype none
module tasi_dpath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tasi_pkg::cmd_t cmd,
	output tasi_pkg::sts_t sts,
	input  wire logic [1:0] mode,
	input  wire logic [tasi_pkg::CITY_W-1:0] city_index,
	input  wire logic [tasi_pkg::COORD_W-1:0] x_coord,
	input  wire logic [tasi_pkg::COORD_W-1:0] y_coord,
	input  wire logic cfg_valid,
	input  wire logic [tasi_pkg::CFG_W-1:0] cfg_data,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [tasi_pkg::COST_W-1:0] pass_cost,
	output logic [tasi_pkg::COST_W-1:0] best_cost,
	output logic improved,
	output logic [tasi_pkg::CITY_W-1:0] tour_city
);
	import tasi_pkg::*;

	logic [COORD_W-1:0] x_mem [MAX_CITIES];
	logic [COORD_W-1:0] y_mem [MAX_CITIES];
	logic [CITY_W-1:0]  tour_mem [MAX_CITIES+1];

	logic [CFG_W-1:0] cfg_q;
	logic [POS_W-1:0] ncl, bp_q, taddr;
	logic [CITY_W-1:0] idx_q, tr_q, twd;
	logic [COORD_W-1:0] xin_q, yin_q, xa_q, ya_q, xb_q, yb_q;
	logic [CITY_W-1:0] win_q [4];
	logic [CITY_W-1:0] ca, cb;
	logic [ROOT_W-1:0] d_cd_q, d_ab_q, d_ac_q, d_bd_q, droot;
	logic ddone;
	logic [RUN_W-1:0] run_q;
	logic [COST_W-1:0] best_q, pc, nb;
	logic imp_q;
	logic ov_q;
	logic [COST_W-1:0] pc_q, bc_q;
	logic io_q;
	logic [CITY_W-1:0] tc_q;

	assign ncl = (cfg_q < CFG_W'(2)) ? POS_W'(2) :
		(cfg_q > CFG_W'(MAX_CITIES)) ? POS_W'(MAX_CITIES) : POS_W'(cfg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cfg_q <= CFG_W'(MAX_CITIES);
		else if (cfg_valid) cfg_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= city_index;
			xin_q <= x_coord;
			yin_q <= y_coord;
		end
		if (cmd.load) begin
			x_mem[idx_q] <= xin_q;
			y_mem[idx_q] <= yin_q;
		end
		if (cmd.bp_clr) bp_q <= '0;
		else if (cmd.bp_inc) bp_q <= bp_q + POS_W'(1);
	end

	always_comb begin
		case (cmd.tour_op)
			T_RD_IDX: taddr = POS_W'(idx_q);
			T_FILL:   taddr = bp_q;
			default:  taddr = bp_q + POS_W'(cmd.off);
		endcase
		case (cmd.tour_op)
			T_FILL:  twd = (bp_q == ncl) ? '0 : bp_q[CITY_W-1:0];
			T_WR_C:  twd = win_q[2];
			default: twd = win_q[1];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.tour_op == T_FILL || cmd.tour_op == T_WR_C || cmd.tour_op == T_WR_B)
			tour_mem[taddr] <= twd;
		if (cmd.tour_op == T_RD || cmd.tour_op == T_RD_IDX)
			tr_q <= tour_mem[taddr];
		if (cmd.shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= tr_q;
		end
	end

	always_comb begin
		case (cmd.pair)
			P_AB:    begin ca = win_q[0]; cb = win_q[1]; end
			P_AC:    begin ca = win_q[0]; cb = win_q[2]; end
			P_BD:    begin ca = win_q[1]; cb = win_q[3]; end
			default: begin ca = win_q[2]; cb = win_q[3]; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.crd) begin
			xa_q <= x_mem[ca];
			ya_q <= y_mem[ca];
			xb_q <= x_mem[cb];
			yb_q <= y_mem[cb];
		end
	end

	tasi_dist u_dist (
		.clk(clk), .arst_n(arst_n), .start(cmd.dstart),
		.xa(xa_q), .ya(ya_q), .xb(xb_q), .yb(yb_q),
		.done(ddone), .root(droot)
	);

	always_ff @(posedge clk) begin
		if (cmd.dsave) begin
			case (cmd.pair)
				P_AB:    d_ab_q <= droot;
				P_AC:    d_ac_q <= droot;
				P_BD:    d_bd_q <= droot;
				default: d_cd_q <= droot;
			endcase
		end
		case (cmd.run_op)
			R_CLR: begin
				run_q <= '0;
				imp_q <= 1'b0;
			end
			R_ADD: run_q <= run_q + RUN_W'(droot);
			R_SWAP: begin
				run_q <= run_q + RUN_W'(d_ac_q) + RUN_W'(d_bd_q)
					- RUN_W'(d_ab_q) - RUN_W'(d_cd_q);
				imp_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign pc = (run_q > RUN_W'(COST_MAX)) ? COST_MAX : run_q[COST_W-1:0];
	assign nb = (pc < best_q) ? pc : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= COST_MAX;
			ov_q   <= 1'b0;
		end else begin
			if (cmd.best_rst) best_q <= COST_MAX;
			else if (cmd.res_op == RES_PASS) best_q <= nb;
			if (cmd.res_op != RES_NONE) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.res_op)
			RES_ZERO: begin
				pc_q <= '0; bc_q <= best_q; io_q <= 1'b0; tc_q <= '0;
			end
			RES_PASS: begin
				pc_q <= pc; bc_q <= nb; io_q <= imp_q; tc_q <= '0;
			end
			RES_READ: begin
				pc_q <= '0; bc_q <= best_q; io_q <= 1'b0;
				tc_q <= (POS_W'(idx_q) <= ncl) ? tr_q : '0;
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign pass_cost = pc_q;
	assign best_cost = bc_q;
	assign improved  = io_q;
	assign tour_city = tc_q;

	assign sts.mode      = mode;
	assign sts.bp_eq_n   = bp_q == ncl;
	assign sts.bp_eq_nm3 = bp_q == ncl - POS_W'(3);
	assign sts.few       = ncl == POS_W'(2);
	assign sts.dist_done = ddone;
	assign sts.better    = (RUN_W'(d_ac_q) + RUN_W'(d_bd_q)) <
		(RUN_W'(d_ab_q) + RUN_W'(d_cd_q));
	assign sts.out_busy  = ov_q && !out_ready;
endmodule
`default_nettype wire

// ===== rtl/tasi_ctrl.sv =====
// Controller: sequences load, tour fill, cost pass with swap search, and tour read.
`default_nettype none
module tasi_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire tasi_pkg::sts_t sts,
	output tasi_pkg::cmd_t cmd
);
	import tasi_pkg::*;

	typedef enum logic [24:0] {
		S_IDLE  = 25'h0000001, S_LOAD  = 25'h0000002, S_FILL  = 25'h0000004,
		S_RDX   = 25'h0000008, S_RDW   = 25'h0000010, S_I0    = 25'h0000020,
		S_I1    = 25'h0000040, S_IN    = 25'h0000080, S_IRD   = 25'h0000100,
		S_ISH   = 25'h0000200, S_ICRD  = 25'h0000400, S_IDST  = 25'h0000800,
		S_IWAIT = 25'h0001000, S_W0    = 25'h0002000, S_W1    = 25'h0004000,
		S_W2    = 25'h0008000, S_W3    = 25'h0010000, S_W4    = 25'h0020000,
		S_CRD   = 25'h0040000, S_DST   = 25'h0080000, S_DWAIT = 25'h0100000,
		S_EVAL  = 25'h0200000, S_WRB   = 25'h0400000, S_NEXT  = 25'h0800000,
		S_DONE  = 25'h1000000
	} state_t;

	state_t st_q, st_d;
	pair_t pair_q, pair_d;
	res_op_t res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			pair_q <= P_CD;
			res_q  <= RES_NONE;
		end else begin
			st_q   <= st_d;
			pair_q <= pair_d;
			res_q  <= res_d;
		end
	end

	assign in_ready = st_q == S_IDLE;

	always_comb begin
		cmd    = '0;
		st_d   = st_q;
		pair_d = pair_q;
		res_d  = res_q;
		case (st_q)
			S_IDLE: if (in_valid) begin
				cmd.capture = 1'b1;
				case (sts.mode)
					MODE_LOAD: st_d = S_LOAD;
					MODE_INIT: begin cmd.bp_clr = 1'b1; st_d = S_FILL; end
					MODE_PASS: begin
						cmd.bp_clr = 1'b1;
						cmd.run_op = R_CLR;
						st_d = S_I0;
					end
					default: st_d = S_RDX;
				endcase
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				res_d = RES_ZERO;
				st_d = S_DONE;
			end
			S_FILL: begin
				cmd.tour_op = T_FILL;
				cmd.bp_inc = 1'b1;
				if (sts.bp_eq_n) begin
					cmd.best_rst = 1'b1;
					res_d = RES_ZERO;
					st_d = S_DONE;
				end
			end
			S_RDX: begin cmd.tour_op = T_RD_IDX; st_d = S_RDW; end
			S_RDW: begin res_d = RES_READ; st_d = S_DONE; end
			S_I0:  begin cmd.tour_op = T_RD; st_d = S_I1; end
			S_I1:  begin cmd.shift = 1'b1; st_d = S_IN; end
			S_IN:  begin cmd.bp_inc = 1'b1; st_d = S_IRD; end
			S_IRD: begin cmd.tour_op = T_RD; st_d = S_ISH; end
			S_ISH: begin cmd.shift = 1'b1; st_d = S_ICRD; end
			S_ICRD: begin cmd.crd = 1'b1; cmd.pair = P_CD; st_d = S_IDST; end
			S_IDST: begin cmd.dstart = 1'b1; st_d = S_IWAIT; end
			S_IWAIT: if (sts.dist_done) begin
				cmd.run_op = R_ADD;
				if (!sts.bp_eq_n) st_d = S_IN;
				else if (sts.few) begin res_d = RES_PASS; st_d = S_DONE; end
				else begin cmd.bp_clr = 1'b1; st_d = S_W0; end
			end
			S_W0: begin cmd.tour_op = T_RD; cmd.off = 2'd0; st_d = S_W1; end
			S_W1: begin cmd.tour_op = T_RD; cmd.off = 2'd1; cmd.shift = 1'b1; st_d = S_W2; end
			S_W2: begin cmd.tour_op = T_RD; cmd.off = 2'd2; cmd.shift = 1'b1; st_d = S_W3; end
			S_W3: begin cmd.tour_op = T_RD; cmd.off = 2'd3; cmd.shift = 1'b1; st_d = S_W4; end
			S_W4: begin cmd.shift = 1'b1; pair_d = P_CD; st_d = S_CRD; end
			S_CRD: begin cmd.crd = 1'b1; cmd.pair = pair_q; st_d = S_DST; end
			S_DST: begin cmd.dstart = 1'b1; st_d = S_DWAIT; end
			S_DWAIT: if (sts.dist_done) begin
				cmd.dsave = 1'b1;
				cmd.pair = pair_q;
				if (pair_q == P_BD) st_d = S_EVAL;
				else begin pair_d = pair_t'(pair_q + 2'd1); st_d = S_CRD; end
			end
			S_EVAL: begin
				if (sts.better) begin
					cmd.tour_op = T_WR_C;
					cmd.off = 2'd1;
					cmd.run_op = R_SWAP;
					st_d = S_WRB;
				end else st_d = S_NEXT;
			end
			S_WRB: begin cmd.tour_op = T_WR_B; cmd.off = 2'd2; st_d = S_NEXT; end
			S_NEXT: begin
				if (sts.bp_eq_nm3) begin res_d = RES_PASS; st_d = S_DONE; end
				else begin cmd.bp_inc = 1'b1; st_d = S_W0; end
			end
			S_DONE: if (!sts.out_busy) begin
				cmd.res_op = res_q;
				st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/tour_adjacent_swap_improver.sv =====
// Top level: adjacent-swap tour improver with controller and datapath.
// One word at a time: load, tour reset, tour read or pass. A pass walks the tour
// cost and then searches for swaps, both paced by the shared distance unit
// (squaring plus a 25-bit root per edge).
// The next word is taken while a finished result waits in the output register.
// Reset (arst_n low): controller idle, no result, best cost all ones, n = 256.
`default_nettype none
module tour_adjacent_swap_improver (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [1:0] mode,
	input  wire logic [tasi_pkg::CITY_W-1:0] city_index,
	input  wire logic [tasi_pkg::COORD_W-1:0] x_coord,
	input  wire logic [tasi_pkg::COORD_W-1:0] y_coord,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [tasi_pkg::COST_W-1:0] pass_cost,
	output logic [tasi_pkg::COST_W-1:0] best_cost,
	output logic improved,
	output logic [tasi_pkg::CITY_W-1:0] tour_city,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [tasi_pkg::CFG_W-1:0] cfg_data
);
	import tasi_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tasi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	tasi_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.mode(mode), .city_index(city_index), .x_coord(x_coord), .y_coord(y_coord),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.pass_cost(pass_cost), .best_cost(best_cost),
		.improved(improved), .tour_city(tour_city)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
	a_best_le_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pass_cost == '0) || (best_cost <= pass_cost))
		else $error("best above pass cost");
	a_imp_no_city: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && improved |-> tour_city == '0) else $error("improved with city");
endmodule
`default_nettype wire

// ===== bench/tb_tour_adjacent_swap_improver.sv =====
// Testbench for the tour improver: scoreboard against a behavioral tour model.
`timescale 1ns / 100ps
module tb_tour_adjacent_swap_improver;
	import tasi_pkg::*;

	typedef struct {
		logic [COST_W-1:0] pass_cost;
		logic [COST_W-1:0] best_cost;
		logic              improved;
		logic [CITY_W-1:0] tour_city;
	} answer_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          mode;
	logic [CITY_W-1:0]   city_index;
	logic [COORD_W-1:0]  x_coord;
	logic [COORD_W-1:0]  y_coord;
	logic                out_valid;
	logic                out_ready;
	logic [COST_W-1:0]   pass_cost;
	logic [COST_W-1:0]   best_cost;
	logic                improved;
	logic [CITY_W-1:0]   tour_city;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data;

	answer_t             answers_due[$];
	logic [COORD_W-1:0]  mdl_x[MAX_CITIES];
	logic [COORD_W-1:0]  mdl_y[MAX_CITIES];
	logic [CITY_W-1:0]   mdl_tour[MAX_CITIES+1];
	logic [COST_W-1:0]   mdl_best;
	logic [CFG_W-1:0]    mdl_ncfg;
	int                  errors;
	int                  idle_pct;
	int                  stall_pct;
	int                  words_sent;
	int                  quiet_cycles;

	localparam int QUIET_LIMIT = 400000;

	tour_adjacent_swap_improver u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .city_index(city_index), .x_coord(x_coord), .y_coord(y_coord),
		.out_valid(out_valid), .out_ready(out_ready),
		.pass_cost(pass_cost), .best_cost(best_cost), .improved(improved),
		.tour_city(tour_city),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] edge_len(logic [CITY_W-1:0] a, logic [CITY_W-1:0] b);
		logic [63:0] dx;
		logic [63:0] dy;
		dx = (mdl_x[a] > mdl_x[b]) ? mdl_x[a] - mdl_x[b] : mdl_x[b] - mdl_x[a];
		dy = (mdl_y[a] > mdl_y[b]) ? mdl_y[a] - mdl_y[b] : mdl_y[b] - mdl_y[a];
		return int_sqrt((dx * dx + dy * dy) << (2 * FRAC_BITS));
	endfunction

	function automatic int cities_used();
		if (mdl_ncfg < 2)
			return 2;
		if (mdl_ncfg > MAX_CITIES)
			return MAX_CITIES;
		return int'(mdl_ncfg);
	endfunction

	function automatic answer_t apply_word(logic [1:0] m, logic [CITY_W-1:0] idx,
			logic [COORD_W-1:0] xv, logic [COORD_W-1:0] yv);
		answer_t     ans;
		int          n;
		logic [63:0] run;
		logic [63:0] removed;
		logic [63:0] added;
		logic [CITY_W-1:0] a, b, c, d;
		n = cities_used();
		ans.pass_cost = 0;
		ans.improved = 1'b0;
		ans.tour_city = 0;
		case (m)
			MODE_LOAD: begin
				mdl_x[idx] = xv;
				mdl_y[idx] = yv;
			end
			MODE_INIT: begin
				for (int p = 0; p < n; p++)
					mdl_tour[p] = p[CITY_W-1:0];
				mdl_tour[n] = 0;
				mdl_best = COST_MAX;
			end
			MODE_PASS: begin
				run = 0;
				for (int p = 1; p <= n; p++)
					run += edge_len(mdl_tour[p-1], mdl_tour[p]);
				for (int p = 1; p + 2 <= n; p++) begin
					a = mdl_tour[p-1];
					b = mdl_tour[p];
					c = mdl_tour[p+1];
					d = mdl_tour[p+2];
					removed = edge_len(a, b) + edge_len(b, c) + edge_len(c, d);
					added = edge_len(a, c) + edge_len(c, b) + edge_len(b, d);
					if (added < removed) begin
						run = run - removed + added;
						mdl_tour[p] = c;
						mdl_tour[p+1] = b;
						ans.improved = 1'b1;
					end
				end
				ans.pass_cost = (run > {24'd0, COST_MAX}) ? COST_MAX : run[COST_W-1:0];
				if (ans.pass_cost < mdl_best)
					mdl_best = ans.pass_cost;
			end
			default: begin
				if (idx <= n)
					ans.tour_city = mdl_tour[idx];
			end
		endcase
		ans.best_cost = mdl_best;
		return ans;
	endfunction

	task automatic send_word(logic [1:0] m, logic [CITY_W-1:0] idx,
			logic [COORD_W-1:0] xv, logic [COORD_W-1:0] yv);
		@(negedge clk);
		in_valid = 1'b1;
		mode = m;
		city_index = idx;
		x_coord = xv;
		y_coord = yv;
		do @(posedge clk); while (!in_ready);
		answers_due.insert(answers_due.size(), apply_word(m, idx, xv, yv));
		words_sent++;
		@(negedge clk);
		in_valid = 1'b0;
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
	endtask

	task automatic write_cities(int value);
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (10) @(negedge clk);
		in_valid = 1'b0;
		cfg_valid = 1'b1;
		cfg_data = value[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		mdl_ncfg = value[CFG_W-1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? '1 : '0;
			1: return COORD_W'($urandom_range(63));
			default: return COORD_W'($urandom);
		endcase
	endfunction

	task automatic set_idling(int phase);
		case (phase % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 60; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 60; end
			default: begin idle_pct = 25; stall_pct = 25; end
		endcase
	endtask

	task automatic test_directed();
		write_cities(16);
		for (int c = 0; c < 16; c++)
			send_word(MODE_LOAD, CITY_W'(c), COORD_W'($urandom), COORD_W'($urandom));
		send_word(MODE_INIT, '0, '0, '0);
		send_word(MODE_PASS, '0, '0, '0);
		send_word(MODE_PASS, '0, '0, '0);
		send_word(MODE_READ, '0, '0, '0);
		send_word(MODE_READ, CITY_W'(16), '0, '0);
		send_word(MODE_READ, CITY_W'(17), '0, '0);
		write_cities(2);
		send_word(MODE_LOAD, CITY_W'(0), '0, '0);
		send_word(MODE_LOAD, CITY_W'(1), '1, '1);
		send_word(MODE_INIT, '0, '0, '0);
		send_word(MODE_PASS, '0, '0, '0);
		send_word(MODE_READ, CITY_W'(2), '0, '0);
		send_word(MODE_READ, CITY_W'(3), '0, '0);
		write_cities(0);
		send_word(MODE_PASS, '0, '0, '0);
		write_cities(1);
		send_word(MODE_PASS, '0, '0, '0);
		// count above the limit acts as the limit
		write_cities(511);
		send_word(MODE_INIT, '0, '0, '0);
		send_word(MODE_READ, CITY_W'(255), '0, '0);
		write_cities(3);
		send_word(MODE_LOAD, CITY_W'(2), '1, '0);
		send_word(MODE_INIT, '0, '0, '0);
		send_word(MODE_PASS, '0, '0, '0);
		send_word(MODE_PASS, '0, '0, '0);
		send_word(MODE_READ, CITY_W'(1), '0, '0);
	endtask

	task automatic test_random_tours();
		int phase;
		int n;
		int start;
		phase = 0;
		start = words_sent;
		while (words_sent - start < 45) begin
			n = $urandom_range(2, 12);
			write_cities(n);
			set_idling(phase);
			for (int c = 0; c < n; c++)
				send_word(MODE_LOAD, CITY_W'(c), rand_coord(), rand_coord());
			if ($urandom_range(5) != 0)
				send_word(MODE_INIT, '0, '0, '0);
			repeat ($urandom_range(1, 3))
				send_word(MODE_PASS, '0, '0, '0);
			repeat ($urandom_range(1, 3))
				send_word(MODE_READ, CITY_W'($urandom_range(n + 2)), '0, '0);
			phase++;
		end
	endtask

	task automatic test_noise();
		write_cities($urandom_range(2, 8));
		set_idling(3);
		repeat (20)
			send_word(2'($urandom), CITY_W'($urandom), COORD_W'($urandom),
				COORD_W'($urandom));
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		answer_t want;
		if (out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected word pass_cost=%h", $time, pass_cost);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (pass_cost !== want.pass_cost) begin
					$display("%0t: pass_cost exp %h got %h", $time, want.pass_cost, pass_cost);
					errors++;
				end
				if (best_cost !== want.best_cost) begin
					$display("%0t: best_cost exp %h got %h", $time, want.best_cost, best_cost);
					errors++;
				end
				if (improved !== want.improved) begin
					$display("%0t: improved exp %b got %b", $time, want.improved, improved);
					errors++;
				end
				if (tour_city !== want.tour_city) begin
					$display("%0t: tour_city exp %h got %h", $time, want.tour_city, tour_city);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_tour_adjacent_swap_improver: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_LOAD;
		city_index = 0;
		x_coord = 0;
		y_coord = 0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 0;
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		words_sent = 0;
		quiet_cycles = 0;
		mdl_best = COST_MAX;
		mdl_ncfg = 256;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_tours();
		test_noise();
		@(negedge clk);
		in_valid = 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_tour_adjacent_swap_improver: PASS");
		else
			$display("tb_tour_adjacent_swap_improver: FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/tasi_pkg.sv
rtl/tasi_dist.sv
rtl/tasi_dpath.sv
rtl/tasi_ctrl.sv
rtl/tour_adjacent_swap_improver.sv
bench/tb_tour_adjacent_swap_improver.sv
